// ===== rtl/spectrogram_column_engine_unit_assert.svh =====
// Assertion macros shared by the spectrogram column engine modules
`ifndef SPECTROGRAM_COLUMN_ENGINE_UNIT_ASSERT_SVH
`define SPECTROGRAM_COLUMN_ENGINE_UNIT_ASSERT_SVH

// Same-cycle implication, checked out of reset
`define SCE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset
`define SCE_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/sce_pkg.sv =====
// Package: types, constants and table functions of the spectrogram column engine
`timescale 1ns / 1ps

package sce_pkg;

  localparam int FFT_N    = 128;
  localparam int FFT_LOG  = 7;
  localparam int HALF_N   = FFT_N / 2;
  localparam int FIFO_DEPTH = 4;

  // Butterfly datapath width (signed), power word width
  localparam int DW = 26;
  localparam int PW = 48;

  // 20log10(128) in 1/8 dB, full scale offset, floor for zero power
  localparam logic signed [12:0] NORM8     = 13'sd337;
  localparam logic signed [11:0] FULL8     = 12'sd722;
  localparam logic signed [11:0] FLOOR8    = -12'sd800;
  localparam logic [26:0]        DB_SCALE  = 27'd6165;
  localparam logic [26:0]        DB_ROUND  = 27'd32768;

  // Register indexes of the configuration port
  localparam logic [1:0] REG_HOP_LOG2 = 2'd0;
  localparam logic [1:0] REG_MIN_DB   = 2'd1;
  localparam logic [1:0] REG_MAX_DB   = 2'd2;

  localparam logic [2:0]        HOP_RST = 3'd5;
  localparam logic signed [8:0] MIN_RST = -9'sd100;
  localparam logic signed [8:0] MAX_RST = 9'sd0;

  typedef struct packed {
    logic signed [8:0] min_db;
    logic signed [8:0] max_db;
  } sce_cfg_t;

  typedef struct packed {
    logic [15:0] sample;
    logic [6:0]  pos;
    logic        capture;
  } sce_item_t;

  localparam logic [16:0] QSINE [33] = '{
    17'd0, 17'd1608, 17'd3212, 17'd4808, 17'd6393, 17'd7962, 17'd9512, 17'd11039,
    17'd12540, 17'd14010, 17'd15447, 17'd16846, 17'd18205, 17'd19520, 17'd20788,
    17'd22006, 17'd23170, 17'd24279, 17'd25330, 17'd26320, 17'd27246, 17'd28106,
    17'd28899, 17'd29622, 17'd30274, 17'd30853, 17'd31357, 17'd31786, 17'd32138,
    17'd32413, 17'd32610, 17'd32729, 17'd32768
  };

  // sin(2*pi*k/128) in Q1.15
  function automatic logic signed [16:0] sin_q15(input logic [6:0] k);
    logic [5:0]  idx;
    logic [16:0] v;
    idx = k[5] ? (6'd32 - {1'b0, k[4:0]}) : {1'b0, k[4:0]};
    v   = QSINE[idx];
    return k[6] ? -$signed(v) : $signed(v);
  endfunction

  function automatic logic signed [16:0] cos_q15(input logic [6:0] k);
    return sin_q15(k + 7'd32);
  endfunction

  // Periodic Hann window in Q1.15, 0 .. 32768
  function automatic logic [16:0] win_q15(input logic [6:0] k);
    logic signed [17:0] d;
    d = 18'sd32768 - 18'(cos_q15(k));
    return d[17:1];
  endfunction

  function automatic logic [6:0] bitrev7(input logic [6:0] k);
    logic [6:0] r;
    for (int b = 0; b < FFT_LOG; b++) begin
      r[FFT_LOG - 1 - b] = k[b];
    end
    return r;
  endfunction

endpackage

// ===== rtl/sce_if.sv =====
// Channel interfaces: sample input, pixel output and register write port
`timescale 1ns / 1ps

interface sce_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] sample;
  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface sce_out_if;
  logic       valid;
  logic       ready;
  logic [5:0] bin_index;
  logic [7:0] pixel;
  logic       last_bin;
  modport source (output valid, output bin_index, output pixel, output last_bin, input ready);
  modport sink   (input valid, input bin_index, input pixel, input last_bin, output ready);
endinterface

interface sce_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [8:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/spectrogram_column_engine_unit.sv =====
// Top level: spectrogram column engine, front end, queue and back end
`timescale 1ns / 1ps
// Order: a sample that opens no frame is stored in the ring once it leaves the queue; a
// frame-opening sample loads the 128-sample frame (read, window, write), runs the FFT as
// 7x64 butterflies, then maps each of its 64 bins to a pixel, and is stored after the last.
// Throughput: one frame at a time, set by the single shared butterfly unit and the per-bin
// normalise/log/divide sequencer; the 4-entry queue takes samples meanwhile.
// Reset (rst_n low, synchronous): ring reads as zero, write position 0, registers to defaults.

module spectrogram_column_engine_unit (
  input  logic      clk,
  input  logic      rst_n,
  sce_in_if.sink    in_ch,
  sce_out_if.source out_ch,
  sce_cfg_if.sink   cfg_ch
);
  import sce_pkg::*;

  logic      push_valid;
  logic      push_ready;
  sce_item_t push_item;
  logic      pop_valid;
  logic      pop_ready;
  sce_item_t pop_item;
  sce_cfg_t  cfg;

  sce_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .cfg_ch     (cfg_ch),
    .push_valid (push_valid),
    .push_item  (push_item),
    .push_ready (push_ready),
    .cfg        (cfg)
  );

  sce_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_item  (push_item),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_item   (pop_item),
    .pop_ready  (pop_ready)
  );

  sce_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_item  (pop_item),
    .pop_ready (pop_ready),
    .cfg       (cfg),
    .out_ch    (out_ch)
  );

endmodule

// ===== rtl/sce_front.sv =====
// Front end: register file, write position and frame-start classification
`timescale 1ns / 1ps

module sce_front (
  input  logic               clk,
  input  logic               rst_n,
  sce_in_if.sink             in_ch,
  sce_cfg_if.sink            cfg_ch,
  output logic               push_valid,
  output sce_pkg::sce_item_t push_item,
  input  logic               push_ready,
  output sce_pkg::sce_cfg_t  cfg
);
  import sce_pkg::*;

  logic [2:0]        hop_log2_r;
  logic signed [8:0] min_db_r;
  logic signed [8:0] max_db_r;
  logic [6:0]        pos_r;
  logic [6:0]        hop_mask;

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = push_ready;
  assign push_valid   = in_ch.valid;

  // Frame starts where the position is a multiple of the hop
  assign hop_mask            = 7'((8'd1 << hop_log2_r) - 8'd1);
  assign push_item.sample    = in_ch.sample;
  assign push_item.pos       = pos_r;
  assign push_item.capture   = ((pos_r & hop_mask) == 7'd0);

  assign cfg.min_db = min_db_r;
  assign cfg.max_db = max_db_r;

  // Take register writes; ignore indexes beyond the list
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hop_log2_r <= HOP_RST;
      min_db_r   <= MIN_RST;
      max_db_r   <= MAX_RST;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_HOP_LOG2: hop_log2_r <= cfg_ch.data[2:0];
        REG_MIN_DB:   min_db_r   <= $signed(cfg_ch.data);
        REG_MAX_DB:   max_db_r   <= $signed(cfg_ch.data);
        default:      ;
      endcase
    end
  end

  // Advance the write position on each accepted beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= 7'd0;
    end else if (in_ch.valid && push_ready) begin
      pos_r <= pos_r + 7'd1;
    end
  end

endmodule

// ===== rtl/sce_fifo.sv =====
// Short queue between the front end and the back end
`timescale 1ns / 1ps

`include "spectrogram_column_engine_unit_assert.svh"

module sce_fifo (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push_valid,
  input  sce_pkg::sce_item_t push_item,
  output logic               push_ready,
  output logic               pop_valid,
  output sce_pkg::sce_item_t pop_item,
  input  logic               pop_ready
);
  import sce_pkg::*;

  localparam int AW = $clog2(FIFO_DEPTH);

  sce_item_t     mem_r [FIFO_DEPTH];
  logic [AW-1:0] wr_ptr_r;
  logic [AW-1:0] rd_ptr_r;
  logic [AW:0]   cnt_r;
  logic          push;
  logic          pop;

  assign push_ready = (cnt_r != (AW+1)'(FIFO_DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_item   = mem_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  // Store entries
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  // Move pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + AW'(1);
      if (pop)  rd_ptr_r <= rd_ptr_r + AW'(1);
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + (AW+1)'(1);
        2'b01:   cnt_r <= cnt_r - (AW+1)'(1);
        default: ;
      endcase
    end
  end

  `SCE_ASSERT_IMP(a_fifo_bound, 1'b1, cnt_r <= (AW+1)'(FIFO_DEPTH), "queue count over depth")
  `SCE_ASSERT_NXT(a_fifo_inc, push && !pop, cnt_r == $past(cnt_r) + (AW+1)'(1), "count missed push")
  `SCE_ASSERT_NXT(a_fifo_dec, pop && !push, cnt_r == $past(cnt_r) - (AW+1)'(1), "count missed pop")

endmodule

// ===== rtl/sce_back.sv =====
// Back end: sample ring, frame capture, windowed FFT, dB mapping and pixel out
`timescale 1ns / 1ps

`include "spectrogram_column_engine_unit_assert.svh"

module sce_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               pop_valid,
  input  sce_pkg::sce_item_t pop_item,
  output logic               pop_ready,
  input  sce_pkg::sce_cfg_t  cfg,
  sce_out_if.source          out_ch
);
  import sce_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE, ST_LD_RD, ST_LD_MUL, ST_LD_WR,
    ST_BF_RD, ST_BF_MUL, ST_BF_SUM, ST_BF_WA, ST_BF_WB,
    ST_PW_RD, ST_PW_MUL, ST_PW_SUM, ST_NORM, ST_LOG, ST_DB,
    ST_CLAMP, ST_DIV, ST_OUT, ST_STORE
  } state_t;

  state_t st_r;

  // Item
  logic [15:0] smp_r;
  logic [6:0]  pos_r;

  // Counters
  logic [6:0] i_r;
  logic [5:0] j_r;
  logic [2:0] stage_r;
  logic [5:0] k_r;
  logic [2:0] it_r;
  logic [5:0] sh_r;

  // Memories
  logic [15:0]       ring_mem [FFT_N];
  logic [FFT_N-1:0]  ring_vld_r;
  logic [15:0]       ring_q_r;
  logic              ring_v_r;
  logic [2*DW-1:0]   fs_mem [FFT_N];
  logic [2*DW-1:0]   fs_qa_r;
  logic [2*DW-1:0]   fs_qb_r;

  logic [6:0]      ring_raddr;
  logic            ring_we;
  logic            fs_we;
  logic [6:0]      fs_waddr;
  logic [2*DW-1:0] fs_wdata;
  logic [6:0]      fs_raddr_a;
  logic [6:0]      fs_raddr_b;

  // Datapath registers
  logic signed [33:0]   wprod_r;
  logic signed [16:0]   tw_c_r;
  logic signed [16:0]   tw_s_r;
  logic signed [42:0]   p_cr_r, p_si_r, p_ci_r, p_sr_r;
  logic signed [DW-1:0] a_re_r, a_im_r;
  logic signed [DW-1:0] tr_r, ti_r;
  logic signed [51:0]   sq_re_r, sq_im_r;
  logic [PW-1:0]        p_r;
  logic [30:0]          m_r;
  logic [7:0]           frac_r;
  logic signed [11:0]   gain_r;
  logic [19:0]          rem_r;
  logic [19:0]          dsh_r;
  logic [7:0]           q_r;

  // Output register
  logic       out_valid_r;
  logic [5:0] out_bin_r;
  logic [7:0] out_pix_r;
  logic       out_last_r;

  // Butterfly addressing
  logic [5:0] kmask;
  logic [5:0] kk;
  logic [6:0] bf_a;
  logic [6:0] bf_b;
  logic [6:0] tw_idx;

  // Combinational helpers
  logic signed [DW-1:0] b_re, b_im, q_re, q_im;
  logic signed [15:0]   ld_x;
  logic signed [33:0]   ld_rnd;
  logic signed [43:0]   sum_r_t, sum_i_t;
  logic [61:0]          msq;
  logic [13:0]          lq;
  logic [26:0]          db_lin;
  logic signed [12:0]   v13, lo13, hi13, c13;
  logic [12:0]          diff, den;

  assign kmask  = 6'((7'd1 << stage_r) - 7'd1);
  assign kk     = j_r & kmask;
  assign bf_a   = 7'((7'(j_r >> stage_r) << (stage_r + 3'd1))) | {1'b0, kk};
  assign bf_b   = bf_a + 7'(7'd1 << stage_r);
  assign tw_idx = 7'({1'b0, kk} << (3'd6 - stage_r));

  assign b_re = $signed(fs_qb_r[2*DW-1:DW]);
  assign b_im = $signed(fs_qb_r[DW-1:0]);
  assign q_re = $signed(fs_qa_r[2*DW-1:DW]);
  assign q_im = $signed(fs_qa_r[DW-1:0]);

  assign ld_x    = ring_v_r ? $signed(ring_q_r) : 16'sd0;
  assign ld_rnd  = (wprod_r + 34'sd16384) >>> 15;
  assign sum_r_t = 44'(p_cr_r) + 44'(p_si_r) + 44'sd16384;
  assign sum_i_t = 44'(p_ci_r) - 44'(p_sr_r) + 44'sd16384;
  assign msq     = 62'(m_r) * 62'(m_r);
  assign lq      = {6'(6'd47 - sh_r), frac_r};
  assign db_lin  = 27'(lq) * DB_SCALE + DB_ROUND;

  assign v13  = 13'(gain_r) - NORM8;
  assign lo13 = 13'($signed({cfg.min_db, 3'b000}));
  assign hi13 = 13'($signed({cfg.max_db, 3'b000}));
  assign c13  = (v13 < lo13) ? lo13 : ((hi13 < v13) ? hi13 : v13);
  assign diff = 13'(c13 - lo13);
  assign den  = 13'(hi13 - lo13);

  assign pop_ready = (st_r == ST_IDLE);

  // Memory port control
  always_comb begin
    ring_raddr = pos_r + i_r;
    ring_we    = (st_r == ST_STORE);
    fs_we      = 1'b0;
    fs_waddr   = bf_a;
    fs_wdata   = {a_re_r + tr_r, a_im_r + ti_r};
    fs_raddr_a = bf_a;
    fs_raddr_b = bf_b;
    case (st_r)
      ST_LD_WR: begin
        fs_we    = 1'b1;
        fs_waddr = bitrev7(i_r);
        fs_wdata = {DW'(ld_rnd), {DW{1'b0}}};
      end
      ST_BF_WA: begin
        fs_we = 1'b1;
      end
      ST_BF_WB: begin
        fs_we    = 1'b1;
        fs_waddr = bf_b;
        fs_wdata = {a_re_r - tr_r, a_im_r - ti_r};
      end
      ST_PW_RD, ST_PW_MUL: begin
        fs_raddr_a = {1'b0, k_r};
      end
      default: ;
    endcase
  end

  // Sample ring with registered read
  always_ff @(posedge clk) begin
    if (ring_we) begin
      ring_mem[pos_r] <= smp_r;
    end
    ring_q_r <= ring_mem[ring_raddr];
    ring_v_r <= ring_vld_r[ring_raddr];
  end

  // Ring entries read as zero until first written
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ring_vld_r <= '0;
    end else if (ring_we) begin
      ring_vld_r[pos_r] <= 1'b1;
    end
  end

  // Frame store: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (fs_we) begin
      fs_mem[fs_waddr] <= fs_wdata;
    end
    fs_qa_r <= fs_mem[fs_raddr_a];
    fs_qb_r <= fs_mem[fs_raddr_b];
  end

  // Sequencer and datapath
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      // Drop a taken beat; the output state reloads the register itself
      if (out_valid_r && out_ch.ready && st_r != ST_OUT) out_valid_r <= 1'b0;
      case (st_r)
        ST_IDLE: begin
          if (pop_valid) begin
            smp_r <= pop_item.sample;
            pos_r <= pop_item.pos;
            i_r   <= 7'd0;
            st_r  <= pop_item.capture ? ST_LD_RD : ST_STORE;
          end
        end
        // Capture the frame oldest first, window it, store bit-reversed
        ST_LD_RD:  st_r <= ST_LD_MUL;
        ST_LD_MUL: begin
          wprod_r <= ld_x * $signed({1'b0, win_q15(i_r)});
          st_r    <= ST_LD_WR;
        end
        ST_LD_WR: begin
          i_r <= i_r + 7'd1;
          if (i_r == 7'(FFT_N - 1)) begin
            stage_r <= 3'd0;
            j_r     <= 6'd0;
            st_r    <= ST_BF_RD;
          end else begin
            st_r <= ST_LD_RD;
          end
        end
        // One radix-2 butterfly per pass
        ST_BF_RD: begin
          tw_c_r <= cos_q15(tw_idx);
          tw_s_r <= sin_q15(tw_idx);
          st_r   <= ST_BF_MUL;
        end
        ST_BF_MUL: begin
          p_cr_r <= tw_c_r * b_re;
          p_si_r <= tw_s_r * b_im;
          p_ci_r <= tw_c_r * b_im;
          p_sr_r <= tw_s_r * b_re;
          a_re_r <= q_re;
          a_im_r <= q_im;
          st_r   <= ST_BF_SUM;
        end
        ST_BF_SUM: begin
          tr_r <= DW'(sum_r_t >>> 15);
          ti_r <= DW'(sum_i_t >>> 15);
          st_r <= ST_BF_WA;
        end
        ST_BF_WA: st_r <= ST_BF_WB;
        ST_BF_WB: begin
          j_r <= j_r + 6'd1;
          if (j_r == 6'(HALF_N - 1)) begin
            if (stage_r == 3'(FFT_LOG - 1)) begin
              k_r  <= 6'd0;
              st_r <= ST_PW_RD;
            end else begin
              stage_r <= stage_r + 3'd1;
              st_r    <= ST_BF_RD;
            end
          end else begin
            st_r <= ST_BF_RD;
          end
        end
        // Power of one bin
        ST_PW_RD:  st_r <= ST_PW_MUL;
        ST_PW_MUL: begin
          sq_re_r <= q_re * q_re;
          sq_im_r <= q_im * q_im;
          st_r    <= ST_PW_SUM;
        end
        ST_PW_SUM: begin
          p_r  <= sq_re_r[PW-1:0] + sq_im_r[PW-1:0];
          sh_r <= 6'd0;
          st_r <= ST_NORM;
        end
        // Normalise one bit a cycle
        ST_NORM: begin
          if (p_r == '0) begin
            gain_r <= FLOOR8;
            st_r   <= ST_CLAMP;
          end else if (p_r[PW-1]) begin
            m_r    <= p_r[PW-1:PW-31];
            frac_r <= 8'd0;
            it_r   <= 3'd0;
            st_r   <= ST_LOG;
          end else begin
            p_r  <= p_r << 1;
            sh_r <= sh_r + 6'd1;
          end
        end
        // One fraction bit of log2 per squaring
        ST_LOG: begin
          if (msq[61]) begin
            m_r    <= msq[61:31];
            frac_r <= {frac_r[6:0], 1'b1};
          end else begin
            m_r    <= msq[60:30];
            frac_r <= {frac_r[6:0], 1'b0};
          end
          it_r <= it_r + 3'd1;
          if (it_r == 3'd7) st_r <= ST_DB;
        end
        ST_DB: begin
          gain_r <= $signed({1'b0, db_lin[26:16]}) - FULL8;
          st_r   <= ST_CLAMP;
        end
        ST_CLAMP: begin
          rem_r <= 20'((21'(diff) << 8) - 21'(diff));
          dsh_r <= {den, 7'b0};
          q_r   <= 8'd0;
          it_r  <= 3'd0;
          st_r  <= (hi13 > lo13) ? ST_DIV : ST_OUT;
        end
        // Restoring divide, one quotient bit a cycle
        ST_DIV: begin
          if (rem_r >= dsh_r) begin
            rem_r <= rem_r - dsh_r;
            q_r   <= {q_r[6:0], 1'b1};
          end else begin
            q_r <= {q_r[6:0], 1'b0};
          end
          dsh_r <= dsh_r >> 1;
          it_r  <= it_r + 3'd1;
          if (it_r == 3'd7) st_r <= ST_OUT;
        end
        ST_OUT: begin
          if (!out_valid_r || out_ch.ready) begin
            out_valid_r <= 1'b1;
            out_bin_r   <= k_r;
            out_pix_r   <= q_r;
            out_last_r  <= (k_r == 6'(HALF_N - 1));
            k_r         <= k_r + 6'd1;
            st_r        <= (k_r == 6'(HALF_N - 1)) ? ST_STORE : ST_PW_RD;
          end
        end
        ST_STORE: st_r <= ST_IDLE;
        default:  st_r <= ST_IDLE;
      endcase
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.bin_index = out_bin_r;
  assign out_ch.pixel     = out_pix_r;
  assign out_ch.last_bin  = out_last_r;

  `SCE_ASSERT_IMP(a_last_bin, out_valid_r && out_last_r, out_bin_r == 6'(HALF_N - 1), "last beat not top bin")
  `SCE_ASSERT_NXT(a_pop_idle, pop_valid && pop_ready, st_r == ST_LD_RD || st_r == ST_STORE, "pop outside idle")
  `SCE_ASSERT_NXT(a_store_once, st_r == ST_STORE, st_r == ST_IDLE, "ring write not followed by idle")

endmodule

// ===== tb/spectrogram_column_engine_unit_tb.sv =====
// Testbench for the spectrogram column engine: checks each pixel beat against a local model
`timescale 1ns / 1ps

module spectrogram_column_engine_unit_tb;
  import sce_pkg::*;

  typedef struct packed {
    logic [5:0] bin_index;
    logic [7:0] pixel;
    logic       last_bin;
  } pixel_beat_t;

  typedef enum logic [1:0] { ROW_SAMPLE, ROW_CFG } row_kind_t;

  typedef struct {
    row_kind_t   kind;
    logic [1:0]  index;
    logic [15:0] value;
    bit          flat;   // whole column known to be gray level zero
  } stim_row_t;

  localparam int NROWS = 23;
  localparam int FRAME_SLACK = 60;

  // Register index with no register behind it
  localparam logic [1:0] REG_UNUSED = 2'd3;

  localparam int SINE_Q[33] = '{
    0, 1608, 3212, 4808, 6393, 7962, 9512, 11039, 12540, 14010, 15447,
    16846, 18205, 19520, 20788, 22006, 23170, 24279, 25330, 26320, 27246,
    28106, 28899, 29622, 30274, 30853, 31357, 31786, 32138, 32413, 32610,
    32729, 32768
  };

  logic clk;
  logic rst_n;

  sce_in_if  in_ch ();
  sce_out_if out_ch ();
  sce_cfg_if cfg_ch ();

  spectrogram_column_engine_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source),
    .cfg_ch (cfg_ch.sink)
  );

  // Model state
  logic [15:0]       ring [FFT_N];
  logic [6:0]        wr_pos;
  logic [2:0]        hop_sel;
  logic signed [8:0] lo_db;
  logic signed [8:0] hi_db;
  pixel_beat_t       pixel_q[$];

  int idle_pct;
  int stall_pct;
  int hold_left;
  bit flat_col;
  int mismatches;

  // Clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Run limit
  initial begin
    #400_000_000;
    $display("FAIL spectrogram_column_engine_unit");
    $finish;
  end

  function automatic int sine_of(int k);
    int q;
    int r;
    int v;
    q = (k >> 5) & 3;
    r = k & 31;
    v = (q & 1) ? SINE_Q[32 - r] : SINE_Q[r];
    return (q & 2) ? -v : v;
  endfunction

  function automatic longint round_q15(longint v);
    return (v + 16384) >>> 15;
  endfunction

  function automatic int log2_frac8(longint unsigned p);
    int e;
    int frac;
    longint unsigned m;
    e = 0;
    frac = 0;
    while (e < 63 && (p >> (e + 1)) != 0) e++;
    m = (e > 30) ? (p >> (e - 30)) : (p << (30 - e));
    for (int i = 0; i < 8; i++) begin
      m = (m * m) >> 30;
      frac = frac << 1;
      if (m >= 64'h8000_0000) begin
        m = m >> 1;
        frac = frac | 1;
      end
    end
    return e * 256 + frac;
  endfunction

  // Window, transform and map the frame that starts at the write position
  task automatic predict_column(input int start, input bit flat);
    longint re [FFT_N];
    longint im [FFT_N];
    longint tr;
    longint ti;
    longint c;
    longint s;
    longint unsigned pw;
    int r;
    int a;
    int b;
    int h;
    int g8;
    int v;
    int cl;
    int lo;
    int hi;
    int pix;
    pixel_beat_t beat;
    lo = 8 * int'(lo_db);
    hi = 8 * int'(hi_db);
    for (int i = 0; i < FFT_N; i++) begin
      r = 0;
      for (int k = 0; k < 7; k++) r |= ((i >> k) & 1) << (6 - k);
      re[r] = round_q15(longint'($signed(ring[(start + i) % FFT_N])) *
                        longint'((32768 - sine_of(i + 32)) >>> 1));
      im[r] = 0;
    end
    for (int m = 2; m <= FFT_N; m = m * 2) begin
      h = m / 2;
      for (int base = 0; base < FFT_N; base += m) begin
        for (int k = 0; k < h; k++) begin
          c = sine_of(k * (128 / m) + 32);
          s = sine_of(k * (128 / m));
          a = base + k;
          b = a + h;
          tr = round_q15(c * re[b] + s * im[b]);
          ti = round_q15(c * im[b] - s * re[b]);
          re[b] = re[a] - tr;
          im[b] = im[a] - ti;
          re[a] = re[a] + tr;
          im[a] = im[a] + ti;
        end
      end
    end
    for (int k = 0; k < HALF_N; k++) begin
      pw = re[k] * re[k] + im[k] * im[k];
      g8 = -800;
      if (pw != 0) begin
        g8 = int'((longint'(log2_frac8(pw)) * 6165 + 32768) >> 16) - 722;
        if (g8 < -800) g8 = -800;
      end
      v = g8 - 337;
      cl = (v < lo) ? lo : ((hi < v) ? hi : v);
      pix = (hi > lo) ? (cl - lo) * 255 / (hi - lo) : 0;
      beat.bin_index = 6'(k);
      beat.pixel = flat ? 8'd0 : 8'(pix);
      beat.last_bin = (k == HALF_N - 1);
      pixel_q.push_back(beat);
    end
  endtask

  // Track every accepted beat on the three channels
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          REG_HOP_LOG2: hop_sel <= cfg_ch.data[2:0];
          REG_MIN_DB:   lo_db   <= $signed(cfg_ch.data);
          REG_MAX_DB:   hi_db   <= $signed(cfg_ch.data);
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) begin
        if ((int'(wr_pos) & ((1 << hop_sel) - 1)) == 0) predict_column(wr_pos, flat_col);
        ring[wr_pos] <= in_ch.sample;
        wr_pos <= wr_pos + 7'd1;
      end
      if (out_ch.valid && out_ch.ready) begin
        if (pixel_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected pixel beat bin %0d", out_ch.bin_index);
        end else begin
          if (out_ch.bin_index !== pixel_q[0].bin_index || out_ch.pixel !== pixel_q[0].pixel ||
              out_ch.last_bin !== pixel_q[0].last_bin) begin
            mismatches++;
            if (mismatches <= 10)
              $display("pixel mismatch: exp bin %0d pix %0d last %0b, got bin %0d pix %0d last %0b",
                       pixel_q[0].bin_index, pixel_q[0].pixel, pixel_q[0].last_bin,
                       out_ch.bin_index, out_ch.pixel, out_ch.last_bin);
          end
          void'(pixel_q.pop_front());
        end
      end
    end
  end

  // Result sink: random stalls plus long hold-offs on request
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_ch.ready = 1'b0;
      hold_left--;
    end else begin
      out_ch.ready = ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic send_sample(input logic [15:0] s, input bit flat);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    flat_col = flat;
    in_ch.sample = s;
    in_ch.valid = 1'b1;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Hold until every pixel has come and any trailing sample is stored
  task automatic drain;
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (pixel_q.size() != 0) @(posedge clk);
    repeat (FRAME_SLACK) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [8:0] val);
    drain();
    @(negedge clk);
    cfg_ch.index = idx;
    cfg_ch.data = val;
    cfg_ch.valid = 1'b1;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  function automatic logic [15:0] rand_sample();
    case ($urandom_range(3))
      0: return 16'($signed($urandom_range(200)) - 100);
      1: return $urandom_range(1) ? 16'h7FFF : 16'h8000;
      default: return 16'($urandom);
    endcase
  endfunction

  stim_row_t rows [NROWS];

  initial begin
    logic signed [8:0] lo_pick;
    // First sample sees an empty ring; zero power sits below the lower clamp
    rows[0]  = '{ROW_SAMPLE, REG_HOP_LOG2, 16'h7FFF, 1'b1};
    rows[1]  = '{ROW_CFG,    REG_HOP_LOG2, 16'd0,    1'b0};
    rows[2]  = '{ROW_SAMPLE, REG_HOP_LOG2, 16'h8000, 1'b0};
    rows[3]  = '{ROW_SAMPLE, REG_HOP_LOG2, 16'h7FFF, 1'b0};
    rows[4]  = '{ROW_SAMPLE, REG_HOP_LOG2, 16'h0000, 1'b0};
    rows[5]  = '{ROW_SAMPLE, REG_HOP_LOG2, 16'hFFFF, 1'b0};
    rows[6]  = '{ROW_CFG,    REG_MIN_DB,   16'h160,  1'b0};  // -160
    rows[7]  = '{ROW_SAMPLE, REG_HOP_LOG2, 16'h0001, 1'b0};
    // Equal clamp bounds: flat black column
    rows[8]  = '{ROW_CFG,    REG_MIN_DB,   16'h000,  1'b0};
    rows[9]  = '{ROW_SAMPLE, REG_HOP_LOG2, 16'h5555, 1'b1};
    // Inverted bounds: flat black column
    rows[10] = '{ROW_CFG,    REG_MAX_DB,   16'h160,  1'b0};
    rows[11] = '{ROW_SAMPLE, REG_HOP_LOG2, 16'hAAAA, 1'b1};
    // Bounds beyond the stated range, taken as 9-bit two's complement
    rows[12] = '{ROW_CFG,    REG_MIN_DB,   16'h100,  1'b0};
    rows[13] = '{ROW_CFG,    REG_MAX_DB,   16'h0FF,  1'b0};
    rows[14] = '{ROW_SAMPLE, REG_HOP_LOG2, 16'h1234, 1'b0};
    // Unknown register index is dropped
    rows[15] = '{ROW_CFG,    REG_UNUSED,   16'h1FF,  1'b0};
    rows[16] = '{ROW_CFG,    REG_MIN_DB,   16'h160,  1'b0};
    rows[17] = '{ROW_CFG,    REG_MAX_DB,   16'h000,  1'b0};
    // Hop equal to the frame length
    rows[18] = '{ROW_CFG,    REG_HOP_LOG2, 16'd7,    1'b0};
    rows[19] = '{ROW_SAMPLE, REG_HOP_LOG2, 16'h4000, 1'b0};
    rows[20] = '{ROW_SAMPLE, REG_HOP_LOG2, 16'hC000, 1'b0};
    rows[21] = '{ROW_CFG,    REG_HOP_LOG2, 16'd1,    1'b0};
    rows[22] = '{ROW_SAMPLE, REG_HOP_LOG2, 16'h0100, 1'b0};

    for (int i = 0; i < FFT_N; i++) ring[i] = '0;
    wr_pos = '0;
    hop_sel = HOP_RST;
    lo_db = MIN_RST;
    hi_db = MAX_RST;
    mismatches = 0;
    idle_pct = 0;
    stall_pct = 0;
    hold_left = 0;
    flat_col = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.sample = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    out_ch.ready = 1'b0;
    rst_n = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Walk the directed table
    foreach (rows[r]) begin
      if (rows[r].kind == ROW_CFG) write_reg(rows[r].index, rows[r].value[8:0]);
      else send_sample(rows[r].value, rows[r].flat);
    end

    // Random phases: free flow, idle sender, stalling sink, both
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct  = (ph == 1 || ph == 3) ? ((ph == 3) ? 8 : 63) : 0;
      stall_pct = (ph == 2 || ph == 3) ? ((ph == 3) ? 8 : 63) : 0;
      lo_pick = (ph == 0) ? -9'sd160 : 9'($signed($urandom_range(140)) - 160);
      write_reg(REG_HOP_LOG2, 9'($urandom_range(7, 3)));
      write_reg(REG_MIN_DB, lo_pick);
      write_reg(REG_MAX_DB, (ph == 0) ? 9'sd0 :
                9'(int'(lo_pick) + 1 + $urandom_range(-int'(lo_pick) - 1)));
      for (int n = 0; n < 65; n++) begin
        if (ph == 2 && n == 4) hold_left = 30000;
        if (ph == 1 && n == 30) drain();
        send_sample(rand_sample(), 1'b0);
      end
    end

    drain();
    if (mismatches == 0 && pixel_q.size() == 0) begin
      $display("PASS spectrogram_column_engine_unit");
    end else begin
      $display("FAIL spectrogram_column_engine_unit");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/sce_pkg.sv
rtl/sce_if.sv
rtl/sce_front.sv
rtl/sce_fifo.sv
rtl/sce_back.sv
rtl/spectrogram_column_engine_unit.sv
tb/spectrogram_column_engine_unit_tb.sv
